### sv/mlfq_pkg.sv
// Shared types, codes and helper functions of the multilevel feedback thread scheduler.
// Used by mlfq_find and multilevel_feedback_thread_scheduler; depends on nothing.
package mlfq_pkg;

  localparam int THREADS = 64;
  localparam int CPUS    = 4;
  localparam int LEVELS  = 64;

  localparam logic [11:0] QMAX = 12'hFFF;

  // Command codes of the input beat.
  typedef enum logic [2:0] {
    CMD_ENTER,
    CMD_READY,
    CMD_BLOCK,
    CMD_LEAVE,
    CMD_TICK,
    CMD_RESCHED,
    CMD_ENABLE,
    CMD_DISABLE
  } cmd_t;

  // Thread classes.
  localparam logic [2:0] CLS_IDLE      = 3'd0;
  localparam logic [2:0] CLS_NORMAL    = 3'd1;
  localparam logic [2:0] CLS_DRIVER    = 3'd2;
  localparam logic [2:0] CLS_RT        = 3'd3;
  localparam logic [2:0] CLS_RT_DRIVER = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CLASS = 2'd1;
  localparam logic [1:0] ST_DISABLED  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_UNIT_NORMAL    = 3'd0;
  localparam logic [2:0] REG_UNIT_DRIVER    = 3'd1;
  localparam logic [2:0] REG_UNIT_REALTIME  = 3'd2;
  localparam logic [2:0] REG_UNIT_RT_DRIVER = 3'd3;
  localparam logic [2:0] REG_TICK_LENGTH    = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_INFO,
    S_LD_INFO,
    S_DQ_A,
    S_DQ_B,
    S_AFTER_DQ,
    S_EQ_A,
    S_EQ_B,
    S_WB,
    S_TK_GO,
    S_TK_FIND,
    S_TK_DEC,
    S_RN_GO,
    S_RN_FIND,
    S_RN_HEAD,
    S_RN_HRD,
    S_RN_IRD,
    S_RN_DEC,
    S_DONE
  } state_t;

  // Per-thread record kept in one memory word.
  typedef struct packed {
    logic [2:0]  cls;
    logic [5:0]  pri;
    logic [11:0] quant;
    logic [1:0]  cpu;
  } thread_info_t;

  // Result of the top-level search unit.
  typedef struct packed {
    logic       done;
    logic [5:0] level;
  } find_res_t;

  function automatic logic [5:0] band_max(input logic [2:0] k);
    logic [5:0] r;
    case (k)
      CLS_NORMAL:    r = 6'd15;
      CLS_DRIVER:    r = 6'd31;
      CLS_RT:        r = 6'd47;
      CLS_RT_DRIVER: r = 6'd63;
      default:       r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] band_min(input logic [2:0] k);
    logic [5:0] r;
    case (k)
      CLS_NORMAL:    r = 6'd1;
      CLS_DRIVER:    r = 6'd16;
      CLS_RT:        r = 6'd32;
      CLS_RT_DRIVER: r = 6'd48;
      default:       r = 6'd0;
    endcase
    return r;
  endfunction

  // Moves a priority by one step up or down, clamped to the class band.
  function automatic logic [5:0] shift_pri(input logic [2:0] k, input logic [5:0] p,
                                           input logic up, input logic down);
    logic [6:0] n;
    logic [6:0] hi;
    logic [6:0] lo;
    logic [5:0] r;
    hi = {1'b0, band_max(k)};
    lo = {1'b0, band_min(k)};
    if (up) begin
      n = {1'b0, p} + 7'd1;
    end else if (down && p != 6'd0) begin
      n = {1'b0, p} - 7'd1;
    end else begin
      n = {1'b0, p};
    end
    if (n > hi) n = hi;
    if (n < lo) n = lo;
    if (k == CLS_IDLE) begin
      r = 6'd0;
    end else if (k > CLS_RT_DRIVER) begin
      r = p;
    end else begin
      r = n[5:0];
    end
    return r;
  endfunction

  // Quantum of a thread: (band top - priority + 1) times the class unit, capped at QMAX.
  function automatic logic [11:0] quantum_calc(input logic [2:0] k, input logic [5:0] p,
                                               input logic [7:0] unit);
    logic [5:0]  top;
    logic [6:0]  f;
    logic [14:0] prod;
    logic [11:0] r;
    top = band_max(k);
    if (p > top) begin
      f = 7'd1;
    end else begin
      f = {1'b0, top} - {1'b0, p} + 7'd1;
    end
    prod = {8'b0, f} * {7'b0, unit};
    if (k < CLS_NORMAL || k > CLS_RT_DRIVER) begin
      r = QMAX;
    end else if (prod > {3'b0, QMAX}) begin
      r = QMAX;
    end else begin
      r = prod[11:0];
    end
    return r;
  endfunction

endpackage

### sv/mlfq_find.sv
// Iterative search for the highest non-empty level above level 0.
// Scans the 64-bit level mask one byte per cycle from the top; uses mlfq_pkg.
module mlfq_find (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [63:0]           word,
  output mlfq_pkg::find_res_t   res
);
  import mlfq_pkg::*;

  logic        busy;
  logic [2:0]  grp;
  logic [63:0] mask;
  logic [7:0]  chunk;
  logic [2:0]  pos;

  // Select the current byte and find its highest set bit.
  always_comb begin
    chunk = mask[{grp, 3'b000} +: 8];
    pos = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (chunk[i]) pos = 3'(i);
    end
  end

  // One byte per cycle; level 0 never counts as ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      res  <= '0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        mask <= {word[63:1], 1'b0};
        grp  <= 3'd7;
      end else if (busy) begin
        if (chunk != 8'd0) begin
          res.done  <= 1'b1;
          res.level <= {grp, pos};
          busy      <= 1'b0;
        end else if (grp == 3'd0) begin
          res.done  <= 1'b1;
          res.level <= 6'd0;
          busy      <= 1'b0;
        end else begin
          grp <= grp - 3'd1;
        end
      end
    end
  end

endmodule

### sv/multilevel_feedback_thread_scheduler.sv
// Multilevel feedback thread scheduler: 4 CPUs, 64 FIFO ready levels each, 64 threads.
// Enable, disable, a rejected enter and a refused resched finish quickest, enter/ready/block/leave
// take longer, and resched and tick take longest: the level search (one byte per cycle) and the
// single read port of each memory set the time that each beat takes.
// One beat at a time; the next beat is taken in the cycle after the result leaves.
// Reset (synchronous) clears queue flags, level masks, counts and CPU state; the thread
// and level memories hold garbage until written and need no clearing pass.
module multilevel_feedback_thread_scheduler (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] cmd,
  input  logic [5:0] thread_id,
  input  logic [2:0] thread_class,
  input  logic [1:0] cpu_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       switched,
  output logic [5:0] next_thread,
  output logic       next_is_idle,
  output logic [1:0] placed_cpu,
  output logic [1:0] status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import mlfq_pkg::*;

  state_t state, state_next;

  // Working registers of the current beat.
  cmd_t       w_cmd;
  logic [5:0] w_t;
  logic [2:0] w_cls_in;
  logic [1:0] w_c;
  logic [2:0] w_cls;
  logic [5:0] w_pri;
  logic [11:0] w_q;
  logic [1:0] w_cpu;
  logic       w_exp;
  logic       w_run;
  logic [5:0] w_top;
  logic [5:0] w_nt;
  logic       w_nidle;

  // Configuration.
  logic [7:0] unit_normal, unit_driver, unit_realtime, unit_rt_driver, tick_len;

  // Per-thread and per-CPU flip-flop state.
  logic [63:0] queued;
  logic [63:0] nonempty [CPUS];
  logic [6:0]  cnt [CPUS];
  logic [5:0]  cur [CPUS];
  logic [CPUS-1:0] run_idle;
  logic [CPUS-1:0] enabled;

  // Memories.
  thread_info_t info_mem [THREADS];
  logic [5:0]   next_mem [THREADS];
  logic [5:0]   prev_mem [THREADS];
  logic [5:0]   head_mem [CPUS*LEVELS];
  logic [5:0]   tail_mem [CPUS*LEVELS];

  logic         info_we;
  logic [5:0]   info_waddr, info_raddr;
  thread_info_t info_wdata, info_rdata;
  logic         next_we, prev_we, head_we, tail_we;
  logic [5:0]   next_waddr, next_wdata, next_raddr, next_rdata;
  logic [5:0]   prev_waddr, prev_wdata, prev_raddr, prev_rdata;
  logic [7:0]   head_waddr, head_raddr, tail_waddr, tail_raddr;
  logic [5:0]   head_wdata, head_rdata, tail_wdata, tail_rdata;

  logic        fstart;
  find_res_t   fres;
  logic [1:0]  least;
  logic        here;
  logic        accept;
  logic [5:0]  cp;
  logic [7:0]  unit_sel;

  mlfq_find u_find (
    .clk   (clk),
    .rst   (rst),
    .start (fstart),
    .word  (nonempty[w_c]),
    .res   (fres)
  );

  assign in_ready  = (state == S_IDLE) && !out_valid;
  // Configuration is taken only while no beat is in flight or offered.
  assign cfg_ready = (state == S_IDLE) && !out_valid && !in_valid;
  assign accept    = in_valid && in_ready;
  assign here      = queued[w_t] && (w_cpu == w_c);
  assign cp        = run_idle[w_c] ? 6'd0 : w_pri;

  // Least-loaded CPU, lowest index on ties.
  always_comb begin
    least = 2'd0;
    for (int i = 1; i < CPUS; i++) begin
      if (cnt[i] < cnt[least]) least = 2'(i);
    end
  end

  // Quantum unit of the class of the thread just read.
  always_comb begin
    case (info_rdata.cls)
      CLS_NORMAL: unit_sel = unit_normal;
      CLS_DRIVER: unit_sel = unit_driver;
      CLS_RT:     unit_sel = unit_realtime;
      default:    unit_sel = unit_rt_driver;
    endcase
  end

  // Memory arrays with registered reads.
  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_waddr] <= info_wdata;
    info_rdata <= info_mem[info_raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    next_rdata <= next_mem[next_raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    prev_rdata <= prev_mem[prev_raddr];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    head_rdata <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_waddr] <= tail_wdata;
    tail_rdata <= tail_mem[tail_raddr];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory controls.
  always_comb begin
    state_next = state;
    info_we    = 1'b0;
    info_waddr = w_t;
    info_wdata = '{cls: w_cls, pri: w_pri, quant: w_q, cpu: w_cpu};
    info_raddr = w_t;
    next_we    = 1'b0;
    next_waddr = w_t;
    next_wdata = w_t;
    next_raddr = w_t;
    prev_we    = 1'b0;
    prev_waddr = w_t;
    prev_wdata = w_t;
    prev_raddr = w_t;
    head_we    = 1'b0;
    head_waddr = {w_c, w_pri};
    head_wdata = w_t;
    head_raddr = {w_cpu, w_pri};
    tail_we    = 1'b0;
    tail_waddr = {w_c, w_pri};
    tail_wdata = w_t;
    tail_raddr = {w_cpu, w_pri};
    fstart     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(cmd))
            CMD_ENABLE, CMD_DISABLE: state_next = S_DONE;
            CMD_RESCHED: state_next = enabled[cpu_id] ? S_RN_GO : S_DONE;
            CMD_ENTER: state_next = (thread_class > CLS_RT_DRIVER) ? S_DONE : S_RD_INFO;
            default: state_next = S_RD_INFO;
          endcase
        end
      end
      S_RD_INFO: state_next = S_LD_INFO;
      S_LD_INFO: state_next = (w_cmd == CMD_TICK) ? S_TK_GO : S_DQ_A;
      S_DQ_A: begin
        state_next = queued[w_t] ? S_DQ_B : S_AFTER_DQ;
      end
      S_DQ_B: begin
        // Unlink the thread from its level list.
        if (head_rdata == w_t && tail_rdata == w_t) begin
          // Sole entry: only the level mask changes.
        end else if (head_rdata == w_t) begin
          head_we    = 1'b1;
          head_waddr = {w_cpu, w_pri};
          head_wdata = next_rdata;
        end else if (tail_rdata == w_t) begin
          tail_we    = 1'b1;
          tail_waddr = {w_cpu, w_pri};
          tail_wdata = prev_rdata;
        end else begin
          next_we    = 1'b1;
          next_waddr = prev_rdata;
          next_wdata = next_rdata;
          prev_we    = 1'b1;
          prev_waddr = next_rdata;
          prev_wdata = prev_rdata;
        end
        state_next = S_AFTER_DQ;
      end
      S_AFTER_DQ: begin
        case (w_cmd)
          CMD_BLOCK: state_next = S_WB;
          CMD_LEAVE: state_next = S_DONE;
          default:   state_next = S_EQ_A;
        endcase
      end
      S_EQ_A: begin
        tail_raddr = {w_c, w_pri};
        if (nonempty[w_c][w_pri]) begin
          state_next = S_EQ_B;
        end else begin
          head_we    = 1'b1;
          tail_we    = 1'b1;
          state_next = S_WB;
        end
      end
      S_EQ_B: begin
        // Append behind the current tail.
        prev_we    = 1'b1;
        prev_waddr = w_t;
        prev_wdata = tail_rdata;
        next_we    = 1'b1;
        next_waddr = tail_rdata;
        next_wdata = w_t;
        tail_we    = 1'b1;
        state_next = S_WB;
      end
      S_WB: begin
        info_we    = 1'b1;
        state_next = w_run ? S_RN_GO : S_DONE;
      end
      S_TK_GO: begin
        fstart     = 1'b1;
        state_next = S_TK_FIND;
      end
      S_TK_FIND: begin
        if (fres.done) state_next = S_TK_DEC;
      end
      S_TK_DEC: begin
        if (w_top > cp) begin
          if (!run_idle[w_c] && here) begin
            state_next = S_DQ_A;
          end else begin
            state_next = S_RN_GO;
          end
        end else if (run_idle[w_c]) begin
          state_next = S_DONE;
        end else if (w_q > {4'b0, tick_len}) begin
          state_next = S_WB;
        end else if (here) begin
          state_next = S_DQ_A;
        end else begin
          state_next = S_WB;
        end
      end
      S_RN_GO: begin
        fstart     = 1'b1;
        state_next = S_RN_FIND;
      end
      S_RN_FIND: begin
        if (fres.done) state_next = S_RN_HEAD;
      end
      S_RN_HEAD: begin
        head_raddr = {w_c, w_top};
        state_next = (w_top == 6'd0) ? S_RN_DEC : S_RN_HRD;
      end
      S_RN_HRD: begin
        info_raddr = head_rdata;
        state_next = S_RN_IRD;
      end
      S_RN_IRD: begin
        // Reload the chosen thread's quantum.
        info_we    = 1'b1;
        info_waddr = w_nt;
        info_wdata = '{cls: info_rdata.cls, pri: info_rdata.pri,
                       quant: quantum_calc(info_rdata.cls, info_rdata.pri, unit_sel),
                       cpu: info_rdata.cpu};
        state_next = S_RN_DEC;
      end
      S_RN_DEC: state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Datapath, scheduler state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      queued         <= '0;
      run_idle       <= '1;
      enabled        <= '0;
      out_valid      <= 1'b0;
      unit_normal    <= 8'd20;
      unit_driver    <= 8'd20;
      unit_realtime  <= 8'd20;
      unit_rt_driver <= 8'd20;
      tick_len       <= 8'd10;
      for (int i = 0; i < CPUS; i++) begin
        nonempty[i] <= '0;
        cnt[i]      <= '0;
        cur[i]      <= '0;
      end
    end else begin
      // Configuration writes; indexes past the list are dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_UNIT_NORMAL:    unit_normal    <= cfg_data;
          REG_UNIT_DRIVER:    unit_driver    <= cfg_data;
          REG_UNIT_REALTIME:  unit_realtime  <= cfg_data;
          REG_UNIT_RT_DRIVER: unit_rt_driver <= cfg_data;
          REG_TICK_LENGTH:    tick_len       <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            w_cmd        <= cmd_t'(cmd);
            w_t          <= (cmd_t'(cmd) == CMD_TICK) ? cur[cpu_id] : thread_id;
            w_cls_in     <= thread_class;
            w_c          <= cpu_id;
            w_exp        <= 1'b0;
            w_run        <= (cmd_t'(cmd) == CMD_TICK) || (cmd_t'(cmd) == CMD_RESCHED);
            switched     <= 1'b0;
            next_thread  <= '0;
            next_is_idle <= 1'b0;
            placed_cpu   <= '0;
            status       <= ST_OK;
            case (cmd_t'(cmd))
              CMD_ENABLE:  enabled[cpu_id] <= 1'b1;
              CMD_DISABLE: enabled[cpu_id] <= 1'b0;
              CMD_RESCHED: if (!enabled[cpu_id]) status <= ST_DISABLED;
              CMD_ENTER:   if (thread_class > CLS_RT_DRIVER) status <= ST_BAD_CLASS;
              default: ;
            endcase
          end
        end
        S_LD_INFO: begin
          w_cls <= info_rdata.cls;
          w_pri <= info_rdata.pri;
          w_q   <= info_rdata.quant;
          w_cpu <= info_rdata.cpu;
        end
        S_DQ_B: begin
          if (head_rdata == w_t && tail_rdata == w_t) nonempty[w_cpu][w_pri] <= 1'b0;
          if (cnt[w_cpu] != 7'd0) cnt[w_cpu] <= cnt[w_cpu] - 7'd1;
          queued[w_t] <= 1'b0;
        end
        S_AFTER_DQ: begin
          case (w_cmd)
            CMD_ENTER: begin
              w_cls      <= w_cls_in;
              w_pri      <= (w_cls_in == CLS_IDLE) ? 6'd0 : band_max(w_cls_in);
              w_c        <= least;
              placed_cpu <= least;
            end
            CMD_READY: begin
              w_c        <= least;
              placed_cpu <= least;
            end
            CMD_BLOCK: w_pri <= shift_pri(w_cls, w_pri, 1'b1, 1'b0);
            CMD_TICK:  w_pri <= shift_pri(w_cls, w_pri, 1'b0, w_exp);
            default: ;
          endcase
        end
        S_EQ_A: begin
          cnt[w_c]               <= cnt[w_c] + 7'd1;
          queued[w_t]            <= 1'b1;
          w_cpu                  <= w_c;
          nonempty[w_c][w_pri]   <= 1'b1;
        end
        S_TK_FIND: begin
          if (fres.done) w_top <= fres.level;
        end
        S_TK_DEC: begin
          if (w_top > cp) begin
            w_exp <= 1'b0;
          end else if (run_idle[w_c]) begin
            w_run <= 1'b0;
          end else if (w_q > {4'b0, tick_len}) begin
            w_q   <= w_q - {4'b0, tick_len};
            w_run <= 1'b0;
          end else begin
            w_q   <= '0;
            w_exp <= 1'b1;
            if (!here) w_pri <= shift_pri(w_cls, w_pri, 1'b0, 1'b1);
          end
        end
        S_RN_FIND: begin
          if (fres.done) w_top <= fres.level;
        end
        S_RN_HEAD: begin
          w_nidle <= (w_top == 6'd0);
          w_nt    <= '0;
        end
        S_RN_HRD: begin
          w_nt <= head_rdata;
        end
        S_RN_DEC: begin
          // Switch only when the chosen thread differs from the running one.
          if (!(w_nidle == run_idle[w_c] && (w_nidle || cur[w_c] == w_nt))) begin
            run_idle[w_c] <= w_nidle;
            cur[w_c]      <= w_nt;
            enabled[w_c]  <= 1'b0;
            switched      <= 1'b1;
            next_thread   <= w_nt;
            next_is_idle  <= w_nidle;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // An idle switch always reports thread zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && next_is_idle |-> next_thread == 6'd0)
    else $error("idle result carries a thread number");

  // An error status never comes with a switch.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !switched)
    else $error("switch reported together with an error status");

  // The level search reports only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    fres.done |-> (state == S_TK_FIND || state == S_RN_FIND))
    else $error("level search finished outside a wait state");

endmodule
